[design/xxhash32_stream_assert.svh]
// Assertion macros shared by the xxhash32_stream checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef XXHASH32_STREAM_ASSERT_SVH
`define XXHASH32_STREAM_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define XXH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xxhash32_stream: assertion failed");

// Consequent in the cycle after the antecedent.
`define XXH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xxhash32_stream: assertion failed");

`endif

[design/xxh32_pkg.sv]
// Package for the xxhash32_stream block: hash primes, controller states,
// multiplier operation codes and the command and status bundles. No dependencies.
package xxh32_pkg;

  localparam logic [31:0] PRIME1 = 32'd2654435761;
  localparam logic [31:0] PRIME2 = 32'd2246822519;
  localparam logic [31:0] PRIME3 = 32'd3266489917;
  localparam logic [31:0] PRIME4 = 32'd668265263;
  localparam logic [31:0] PRIME5 = 32'd374761393;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FOLD_MUL,
    ST_FOLD_UPD,
    ST_BASE,
    ST_LEN,
    ST_T4_MUL,
    ST_T4_UPD,
    ST_T1_MUL,
    ST_T1_UPD,
    ST_AV1,
    ST_AV2,
    ST_OUT
  } state_e;

  // Operations of the shared multiplier.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_FOLD_WORD,
    MUL_FOLD_LANE,
    MUL_T4_WORD,
    MUL_T4_H,
    MUL_T1_BYTE,
    MUL_T1_H,
    MUL_AV1,
    MUL_AV2
  } mul_op_e;

  typedef struct packed {
    logic    accept;
    mul_op_e op;
    logic    load_carry;
    logic    load_base;
    logic    add_len;
    logic    emit;
  } dp_cmd_t;

  typedef struct packed {
    logic fold_req;
    logic cnt_ge4;
    logic cnt_nz;
  } dp_sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

endpackage

[design/xxh32_in_if.sv]
// Input channel of the xxhash32_stream block: valid/ready plus one message word.
// Depends on nothing.
interface xxh32_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last;

  modport source (output valid, data_word, byte_count, last, input ready);
  modport sink   (input valid, data_word, byte_count, last, output ready);
endinterface

[design/xxh32_out_if.sv]
// Output channel of the xxhash32_stream block: valid/ready plus the finished hash.
// Depends on nothing.
interface xxh32_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash;

  modport source (output valid, hash, input ready);
  modport sink   (input valid, hash, output ready);
endinterface

[design/xxhash32_stream.sv]
// Top level of the streaming XXH32 hasher: controller plus datapath.
// Depends on xxh32_pkg, xxh32_in_if, xxh32_out_if, xxh32_ctrl and xxh32_dp.

// Streaming 32-bit xxHash. A message arrives as beats of one little-endian
// word each, the first byte in bits 7:0, with byte_count giving the valid
// bytes (values above four count as four) and last marking the final beat;
// only the final beat should normally carry fewer than four bytes, although
// short beats earlier are simply appended to the byte stream. One hash beat
// leaves for every input beat with last set. The user must write the seed
// through cfg_we_i/cfg_wdata_i only while the block is idle; the block does
// not enforce this. The seed resets to zero. A non-final beat that does not
// complete a 16-byte stripe leaves the block ready for the next beat.
// A beat that completes a stripe holds off the input while the four lanes
// are updated in turn through the single shared 32x32 multiplier, two
// dependent products per lane. A final beat then passes the base and length
// steps, a multiply and an update step per remaining 4-byte group and single
// byte (at most fifteen buffered bytes), the avalanche and the output.
// The next message may start while the finished hash waits at the output
// register; the block holds off only if a second hash would overwrite it.
module xxhash32_stream
  import xxh32_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  xxh32_in_if.sink    in_i,
  xxh32_out_if.source out_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller owns the handshakes and the order of operations.
  xxh32_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  // The datapath holds the buffered bytes, the lanes, the length and the seed.
  xxh32_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_data_word_i  (in_i.data_word),
    .in_byte_count_i (in_i.byte_count),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .hash_o          (out_o.hash)
  );

endmodule

[design/xxh32_ctrl.sv]
// Controller of the xxhash32_stream block: sequences stripe folds, tail rounds
// and avalanche on the datapath. Depends on xxh32_pkg.
module xxh32_ctrl
  import xxh32_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_last_i,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  output dp_cmd_t cmd_o
);

  state_e     state_q, state_d;
  logic [1:0] lane_q, lane_d;
  logic       last_q, last_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lane_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lane_q      <= lane_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    lane_d           = lane_q;
    last_d           = last_q;
    in_ready_o       = 1'b0;
    cmd_o.accept     = 1'b0;
    cmd_o.op         = MUL_NONE;
    cmd_o.load_carry = 1'b0;
    cmd_o.load_base  = 1'b0;
    cmd_o.add_len    = 1'b0;
    cmd_o.emit       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          last_d       = in_last_i;
          lane_d       = '0;
          if (sts_i.fold_req) begin
            state_d = ST_FOLD_MUL;
          end else if (in_last_i) begin
            state_d = ST_BASE;
          end
        end
      end
      ST_FOLD_MUL: begin
        cmd_o.op = MUL_FOLD_WORD;
        state_d  = ST_FOLD_UPD;
      end
      ST_FOLD_UPD: begin
        cmd_o.op = MUL_FOLD_LANE;
        lane_d   = lane_q + 2'd1;
        if (lane_q == 2'd3) begin
          cmd_o.load_carry = 1'b1;
          state_d          = last_q ? ST_BASE : ST_IDLE;
        end else begin
          state_d = ST_FOLD_MUL;
        end
      end
      ST_BASE: begin
        cmd_o.load_base = 1'b1;
        state_d         = ST_LEN;
      end
      ST_LEN, ST_T4_UPD, ST_T1_UPD: begin
        if (state_q == ST_LEN) begin
          cmd_o.add_len = 1'b1;
        end else if (state_q == ST_T4_UPD) begin
          cmd_o.op = MUL_T4_H;
        end else begin
          cmd_o.op = MUL_T1_H;
        end
        if (sts_i.cnt_ge4) begin
          state_d = ST_T4_MUL;
        end else if (sts_i.cnt_nz) begin
          state_d = ST_T1_MUL;
        end else begin
          state_d = ST_AV1;
        end
      end
      ST_T4_MUL: begin
        cmd_o.op = MUL_T4_WORD;
        state_d  = ST_T4_UPD;
      end
      ST_T1_MUL: begin
        cmd_o.op = MUL_T1_BYTE;
        state_d  = ST_T1_UPD;
      end
      ST_AV1: begin
        cmd_o.op = MUL_AV1;
        state_d  = ST_AV2;
      end
      ST_AV2: begin
        cmd_o.op = MUL_AV2;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[design/xxh32_dp.sv]
// Datapath of the xxhash32_stream block: byte buffer, lanes, hash register,
// seed and the one shared 32x32 multiplier. Depends on xxh32_pkg.
module xxh32_dp
  import xxh32_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic [31:0] in_data_word_i,
  input  logic [2:0]  in_byte_count_i,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  output logic [31:0] hash_o
);

  logic [31:0] seed_q, seed_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] len_q, len_d;
  logic        seen_q, seen_d;

  logic [7:0]  buf_q [16];
  logic [7:0]  buf_d [16];
  logic [7:0]  carry_q [3];
  logic [7:0]  carry_d [3];
  logic [1:0]  carry_cnt_q, carry_cnt_d;
  logic [31:0] lane_q [4];
  logic [31:0] lane_d [4];
  logic [31:0] h_q, h_d;
  logic [31:0] prod_q, prod_d;
  logic [31:0] hash_q, hash_d;

  logic [2:0]  n;
  logic [4:0]  total;
  logic [4:0]  off;
  logic [7:0]  comb [19];
  logic [31:0] word0;
  logic [31:0] mul_a, mul_b, product;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      cnt_q  <= '0;
      len_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      seed_q <= seed_d;
      cnt_q  <= cnt_d;
      len_q  <= len_d;
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q       <= buf_d;
    carry_q     <= carry_d;
    carry_cnt_q <= carry_cnt_d;
    lane_q      <= lane_d;
    h_q         <= h_d;
    prod_q      <= prod_d;
    hash_q      <= hash_d;
  end

  // Merge the buffered bytes with the incoming word; up to 19 bytes in all.
  always_comb begin
    n     = (in_byte_count_i > 3'd4) ? 3'd4 : in_byte_count_i;
    total = 5'(cnt_q) + 5'(n);
    for (int k = 0; k < 16; k++) begin
      off = 5'(k) - 5'(cnt_q);
      if (5'(k) < 5'(cnt_q)) begin
        comb[k] = buf_q[k];
      end else if (off < 5'(n)) begin
        comb[k] = in_data_word_i[{off[1:0], 3'b000} +: 8];
      end else begin
        comb[k] = 8'h00;
      end
    end
    for (int k = 16; k < 19; k++) begin
      off = 5'(k) - 5'(cnt_q);
      if (off < 5'(n)) begin
        comb[k] = in_data_word_i[{off[1:0], 3'b000} +: 8];
      end else begin
        comb[k] = 8'h00;
      end
    end
  end

  assign word0 = {buf_q[3], buf_q[2], buf_q[1], buf_q[0]};

  always_comb begin
    case (cmd_i.op)
      MUL_FOLD_WORD: begin
        mul_a = word0;
        mul_b = PRIME2;
      end
      MUL_FOLD_LANE: begin
        mul_a = rotl(lane_q[0] + prod_q, 13);
        mul_b = PRIME1;
      end
      MUL_T4_WORD: begin
        mul_a = word0;
        mul_b = PRIME3;
      end
      MUL_T4_H: begin
        mul_a = rotl(h_q + prod_q, 17);
        mul_b = PRIME4;
      end
      MUL_T1_BYTE: begin
        mul_a = {24'h000000, buf_q[0]};
        mul_b = PRIME5;
      end
      MUL_T1_H: begin
        mul_a = rotl(h_q + prod_q, 11);
        mul_b = PRIME1;
      end
      MUL_AV1: begin
        mul_a = h_q ^ (h_q >> 15);
        mul_b = PRIME2;
      end
      MUL_AV2: begin
        mul_a = h_q ^ (h_q >> 13);
        mul_b = PRIME3;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    product = mul_a * mul_b;
  end

  always_comb begin
    seed_d      = cfg_we_i ? cfg_wdata_i : seed_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    seen_d      = seen_q;
    buf_d       = buf_q;
    carry_d     = carry_q;
    carry_cnt_d = carry_cnt_q;
    lane_d      = lane_q;
    h_d         = h_q;
    prod_d      = prod_q;
    hash_d      = hash_q;

    if (cmd_i.accept) begin
      for (int k = 0; k < 16; k++) begin
        buf_d[k] = comb[k];
      end
      for (int j = 0; j < 3; j++) begin
        carry_d[j] = comb[16 + j];
      end
      len_d = len_q + 32'(n);
      if (total >= 5'd16) begin
        cnt_d       = '0;
        carry_cnt_d = total[1:0];
        if (!seen_q) begin
          seen_d    = 1'b1;
          lane_d[0] = seed_q + PRIME1 + PRIME2;
          lane_d[1] = seed_q + PRIME2;
          lane_d[2] = seed_q;
          lane_d[3] = seed_q - PRIME1;
        end
      end else begin
        cnt_d = total[3:0];
      end
    end

    case (cmd_i.op)
      MUL_FOLD_WORD, MUL_T4_WORD, MUL_T1_BYTE: begin
        prod_d = product;
        // Consume the bytes just read so the next read is again at the bottom.
        for (int k = 0; k < 16; k++) begin
          if (cmd_i.op == MUL_T1_BYTE) begin
            buf_d[k] = (k < 15) ? buf_q[(k + 1) % 16] : 8'h00;
          end else begin
            buf_d[k] = (k < 12) ? buf_q[(k + 4) % 16] : 8'h00;
          end
        end
        if (cmd_i.op == MUL_T4_WORD) begin
          cnt_d = cnt_q - 4'd4;
        end else if (cmd_i.op == MUL_T1_BYTE) begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      MUL_FOLD_LANE: begin
        // Lanes rotate so the lane being updated is always in place zero.
        lane_d[0] = lane_q[1];
        lane_d[1] = lane_q[2];
        lane_d[2] = lane_q[3];
        lane_d[3] = product;
      end
      MUL_T4_H, MUL_T1_H, MUL_AV1, MUL_AV2: begin
        h_d = product;
      end
      default: begin
      end
    endcase

    if (cmd_i.load_carry) begin
      for (int j = 0; j < 3; j++) begin
        buf_d[j] = carry_q[j];
      end
      cnt_d = 4'(carry_cnt_q);
    end

    if (cmd_i.load_base) begin
      if (seen_q) begin
        h_d = (rotl(lane_q[0], 1) + rotl(lane_q[1], 7)) +
              (rotl(lane_q[2], 12) + rotl(lane_q[3], 18));
      end else begin
        h_d = seed_q + PRIME5;
      end
    end

    if (cmd_i.add_len) begin
      h_d = h_q + len_q;
    end

    if (cmd_i.emit) begin
      hash_d = h_q ^ (h_q >> 16);
      cnt_d  = '0;
      len_d  = '0;
      seen_d = 1'b0;
    end
  end

  assign sts_o.fold_req = (total >= 5'd16);
  assign sts_o.cnt_ge4  = (cnt_q >= 4'd4);
  assign sts_o.cnt_nz   = (cnt_q != 4'd0);
  assign hash_o         = hash_q;

endmodule

[design/xxh32_checker.sv]
// Port-level assertions for xxhash32_stream and the bind that attaches them.
// Depends on xxhash32_stream_assert.svh and the xxhash32_stream top level.
`include "xxhash32_stream_assert.svh"

module xxh32_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_hash_i
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_i;

  // A waiting hash beat stays and keeps its value.
  `XXH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_hash_i))

  // Finishing a message always takes the block away from the input side.
  `XXH_ASSERT_NEXT(a_last_busy, clk_i, rst_ni, in_fire && in_last_i, !in_ready_i)

  // A beat that is not last never produces a hash on its own.
  `XXH_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, in_fire && !in_last_i && !out_valid_i, !out_valid_i)

  // A new hash appears only when the input was held off just before it.
  `XXH_ASSERT_NOW(a_rise_after_work, clk_i, rst_ni, $rose(out_valid_i), $past(!in_ready_i))

endmodule

bind xxhash32_stream xxh32_checker u_xxh32_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_hash_i  (out_o.hash)
);

[test/tb_top.sv]
// Self-checking testbench for the xxhash32_stream block: drives message beats and seed
// writes, predicts every hash in a local XXH32 model and compares the hash beats.
// Depends on xxh32_in_if, xxh32_out_if and xxhash32_stream from the design folder.
module tb_top;

  // Hash primes, kept local so that the prediction stands apart from the design.
  localparam logic [31:0] K_P1 = 32'd2654435761;
  localparam logic [31:0] K_P2 = 32'd2246822519;
  localparam logic [31:0] K_P3 = 32'd3266489917;
  localparam logic [31:0] K_P4 = 32'd668265263;
  localparam logic [31:0] K_P5 = 32'd374761393;

  // QUIET_CYCLES outlasts the fold of a stripe beat, so a quiet span leaves the block idle.
  localparam int QUIET_CYCLES = 40;
  localparam int TAIL_CYCLES  = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_BEATS  = 300;
  localparam int LIMIT_CYCLES = 400000;

  // What the driver does next: present a beat, write the seed once the block is
  // idle, wait for all hashes, stall the receiver, or change the idling rates.
  typedef enum logic [2:0] {
    ACT_BEAT,
    ACT_SEED,
    ACT_DRAIN,
    ACT_HOLD,
    ACT_PACE
  } act_e;

  typedef struct {
    act_e        act;
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
    int          src_pct;
    int          snk_pct;
  } plan_t;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  xxh32_in_if  in_bus ();
  xxh32_out_if out_bus ();

  xxhash32_stream dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  // Work still to be driven, and the hashes that the accepted beats must produce.
  plan_t       plan_q [$];
  logic [31:0] hash_q [$];
  int          beats_planned = 0;

  // Hash counters. Both are updated with nonblocking assignments, so any process
  // that compares them at a clock edge sees the values from before that edge.
  int   hashes_due;
  int   hashes_seen;
  int   hold_asks;
  int   snk_idle;
  logic plan_empty;
  int   err_cnt = 0;

  // Local copy of the hashing state: seed, lanes, buffered bytes, length so far
  // and whether a whole stripe has been folded into the lanes yet.
  logic [31:0] p_seed;
  logic [31:0] p_lane [4];
  logic [7:0]  p_buf  [16];
  int          p_cnt;
  logic [31:0] p_len;
  logic        p_striped;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned r);
    logic [63:0] dbl;
    dbl = {x, x} << r;
    return dbl[63:32];
  endfunction

  // Takes one accepted beat into the model. The valid bytes join the byte stream
  // and every sixteenth byte folds a stripe into the four lanes; the lanes are
  // loaded from the seed in force at the first stripe of each message. On the
  // final beat the hash is finished and queued, and the message state cleared.
  task automatic absorb_word(input logic [31:0] w, input logic [2:0] nb, input logic fin);
    int          take;
    int          pos;
    logic [31:0] grp;
    logic [31:0] h;
    take = (nb > 3'd4) ? 4 : int'(nb);
    for (int i = 0; i < take; i++) begin
      p_buf[p_cnt] = w[8*i +: 8];
      p_cnt++;
      if (p_cnt == 16) begin
        if (!p_striped) begin
          p_lane[0] = p_seed + K_P1 + K_P2;
          p_lane[1] = p_seed + K_P2;
          p_lane[2] = p_seed;
          p_lane[3] = p_seed - K_P1;
          p_striped = 1'b1;
        end
        for (int k = 0; k < 4; k++) begin
          grp = {p_buf[4*k+3], p_buf[4*k+2], p_buf[4*k+1], p_buf[4*k]};
          p_lane[k] = rol(p_lane[k] + grp * K_P2, 13) * K_P1;
        end
        p_cnt = 0;
      end
    end
    p_len += take;
    if (fin) begin
      // A message with no full stripe starts from the seed in force at its end.
      if (p_striped) begin
        h = rol(p_lane[0], 1) + rol(p_lane[1], 7) + rol(p_lane[2], 12) + rol(p_lane[3], 18);
      end else begin
        h = p_seed + K_P5;
      end
      h += p_len;
      pos = 0;
      while (pos + 4 <= p_cnt) begin
        grp = {p_buf[pos+3], p_buf[pos+2], p_buf[pos+1], p_buf[pos]};
        h = rol(h + grp * K_P3, 17) * K_P4;
        pos += 4;
      end
      while (pos < p_cnt) begin
        h = rol(h + {24'd0, p_buf[pos]} * K_P5, 11) * K_P1;
        pos++;
      end
      h ^= h >> 15;
      h *= K_P2;
      h ^= h >> 13;
      h *= K_P3;
      h ^= h >> 16;
      hash_q.push_back(h);
      hashes_due <= hashes_due + 1;
      p_cnt     = 0;
      p_len     = '0;
      p_striped = 1'b0;
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] seen,
                               input logic [31:0] want);
    err_cnt++;
    $display("[%0t] mismatch, %s: got %08h, expected %08h", $time, what, seen, want);
  endtask

  // ---------------------------------------------------------------------------
  // Plan building
  // ---------------------------------------------------------------------------

  task automatic add_beat(input logic [31:0] d, input logic [2:0] nb, input logic fin);
    plan_t e;
    e = '{act: ACT_BEAT, data: d, nbytes: nb, last: fin, src_pct: 0, snk_pct: 0};
    plan_q.push_back(e);
    beats_planned++;
  endtask

  task automatic add_seed(input logic [31:0] s);
    plan_t e;
    e = '{act: ACT_SEED, data: s, nbytes: 3'd0, last: 1'b0, src_pct: 0, snk_pct: 0};
    plan_q.push_back(e);
  endtask

  task automatic add_pace(input int src, input int snk);
    plan_t e;
    e = '{act: ACT_PACE, data: '0, nbytes: 3'd0, last: 1'b0, src_pct: src, snk_pct: snk};
    plan_q.push_back(e);
  endtask

  // A well-formed message of whole words with a final beat of zero to four bytes,
  // now and then spoilt by a short word inside it or an oversized byte count.
  task automatic add_message(input int words);
    logic [2:0] nb;
    for (int i = 0; i < words; i++) begin
      if (i == words - 1) begin
        nb = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      end else begin
        nb = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'd4;
      end
      add_beat($urandom, nb, i == words - 1);
    end
  endtask

  // One idling phase: a fresh seed, then random messages, mostly short, with a
  // new seed every thirty messages. Halfway through, either the sender waits
  // for every outstanding hash or the receiver is told to stall for a while.
  task automatic plan_phase(input int src, input int snk, input logic [31:0] first_seed,
                            input act_e midway);
    plan_t e;
    int    stop;
    int    msgs;
    int    r;
    logic  mid_done;
    add_pace(src, snk);
    add_seed(first_seed);
    stop     = beats_planned + PHASE_BEATS;
    msgs     = 0;
    mid_done = 1'b0;
    while (beats_planned < stop) begin
      r = $urandom_range(99);
      if (r < 70) begin
        add_message($urandom_range(8, 1));
      end else if (r < 95) begin
        add_message($urandom_range(20, 9));
      end else begin
        add_message($urandom_range(48, 21));
      end
      msgs++;
      if (msgs % 30 == 0) begin
        add_seed($urandom);
      end
      if (!mid_done && beats_planned >= stop - PHASE_BEATS / 2) begin
        e = '{act: midway, data: '0, nbytes: 3'd0, last: 1'b0, src_pct: 0, snk_pct: 0};
        plan_q.push_back(e);
        mid_done = 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents the planned beats, and writes the seed only when no hash
  // is outstanding and the input has been quiet long enough for any stripe
  // fold to finish. Every signal gets at most one nonblocking assignment per edge.
  // ---------------------------------------------------------------------------

  int          src_idle;
  int          quiet;
  logic        nx_valid;
  logic [31:0] nx_data;
  logic [2:0]  nx_nbytes;
  logic        nx_last;
  logic        nx_we;
  logic [31:0] nx_wdata;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_bus.valid      <= 1'b0;
      in_bus.data_word  <= '0;
      in_bus.byte_count <= '0;
      in_bus.last       <= 1'b0;
      cfg_we            <= 1'b0;
      cfg_wdata         <= '0;
      hashes_due        <= 0;
      hold_asks         <= 0;
      snk_idle          <= 0;
      plan_empty        <= 1'b0;
      src_idle  = 0;
      quiet     = 0;
      p_seed    = '0;
      p_cnt     = 0;
      p_len     = '0;
      p_striped = 1'b0;
    end else begin
      nx_valid  = in_bus.valid;
      nx_data   = in_bus.data_word;
      nx_nbytes = in_bus.byte_count;
      nx_last   = in_bus.last;
      nx_we     = 1'b0;
      nx_wdata  = cfg_wdata;

      if (in_bus.valid && in_bus.ready) begin
        absorb_word(in_bus.data_word, in_bus.byte_count, in_bus.last);
        nx_valid = 1'b0;
        quiet    = 0;
      end else if (!in_bus.valid && quiet < QUIET_CYCLES) begin
        quiet++;
      end

      // A beat just accepted may be followed at once by the next one, so that
      // valid stays high without being lowered and raised within this edge.
      if (!nx_valid && plan_q.size() > 0) begin
        case (plan_q[0].act)
          ACT_BEAT: begin
            if ($urandom_range(99) >= src_idle) begin
              nx_valid  = 1'b1;
              nx_data   = plan_q[0].data;
              nx_nbytes = plan_q[0].nbytes;
              nx_last   = plan_q[0].last;
              void'(plan_q.pop_front());
            end
          end
          ACT_SEED: begin
            if (hashes_due == hashes_seen && quiet >= QUIET_CYCLES) begin
              nx_we    = 1'b1;
              nx_wdata = plan_q[0].data;
              p_seed   = plan_q[0].data;
              void'(plan_q.pop_front());
            end
          end
          ACT_DRAIN: begin
            if (hashes_due == hashes_seen) begin
              void'(plan_q.pop_front());
            end
          end
          ACT_HOLD: begin
            hold_asks <= hold_asks + 1;
            void'(plan_q.pop_front());
          end
          ACT_PACE: begin
            src_idle = plan_q[0].src_pct;
            snk_idle <= plan_q[0].snk_pct;
            void'(plan_q.pop_front());
          end
          default: begin
            void'(plan_q.pop_front());
          end
        endcase
      end

      in_bus.valid      <= nx_valid;
      in_bus.data_word  <= nx_data;
      in_bus.byte_count <= nx_nbytes;
      in_bus.last       <= nx_last;
      cfg_we            <= nx_we;
      cfg_wdata         <= nx_wdata;
      plan_empty        <= (plan_q.size() == 0) && !nx_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each hash beat against the oldest expectation and drives
  // ready, either at random or held low through a requested stall.
  // ---------------------------------------------------------------------------

  int          hold_seen;
  int          hold_left;
  logic [31:0] want_hash;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hashes_seen   <= 0;
      hold_seen = 0;
      hold_left = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (hash_q.size() == 0) begin
          flag_mismatch("hash beat with none expected", out_bus.hash, 'x);
        end else begin
          want_hash = hash_q.pop_front();
          if (out_bus.hash !== want_hash) begin
            flag_mismatch("hash", out_bus.hash, want_hash);
          end
          hashes_seen <= hashes_seen + 1;
        end
      end
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  // Watchdog on the cycle count.
  int cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.data_word  = '0;
    in_bus.byte_count = '0;
    in_bus.last       = 1'b0;
    out_bus.ready     = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;

    add_pace(38, 72);
    // Directed beats, at the reset seed of zero first. An empty message, then
    // one byte and one full word of extreme values.
    add_beat(32'h0000_0000, 3'd0, 1'b1);
    add_beat(32'hFFFF_FFFF, 3'd1, 1'b1);
    add_beat(32'h0000_0000, 3'd4, 1'b1);
    // At the all-ones seed: exactly one stripe, then fifteen bytes.
    add_seed(32'hFFFF_FFFF);
    add_beat(32'hFFFF_FFFF, 3'd4, 1'b0);
    add_beat(32'h0000_0000, 3'd4, 1'b0);
    add_beat(32'hA5A5_A5A5, 3'd4, 1'b0);
    add_beat(32'h5A5A_5A5A, 3'd4, 1'b1);
    add_beat(32'h0102_0304, 3'd4, 1'b0);
    add_beat(32'hFFFF_FFFF, 3'd4, 1'b0);
    add_beat(32'h8000_0001, 3'd4, 1'b0);
    add_beat(32'h7FFF_FFFE, 3'd3, 1'b1);
    // Short beats inside a message, byte counts above four, an empty beat inside.
    add_beat(32'h1234_5678, 3'd2, 1'b0);
    add_beat(32'h9ABC_DEF0, 3'd4, 1'b0);
    add_beat(32'hDEAD_BEEF, 3'd7, 1'b1);
    add_beat(32'hCAFE_F00D, 3'd5, 1'b0);
    add_beat(32'h0000_0000, 3'd0, 1'b0);
    add_beat(32'h0000_0001, 3'd6, 1'b1);
    // A seed changed part way through a message: the lanes take it at the first
    // stripe, and a short message takes it at its final beat.
    add_beat(32'h1111_1111, 3'd4, 1'b0);
    add_beat(32'h2222_2222, 3'd4, 1'b0);
    add_seed(32'h8000_0000);
    add_beat(32'h3333_3333, 3'd4, 1'b0);
    add_beat(32'h4444_4444, 3'd4, 1'b0);
    add_beat(32'h5555_5555, 3'd3, 1'b1);
    add_beat(32'h0000_0006, 3'd4, 1'b0);
    add_seed(32'h0000_0001);
    add_beat(32'h0000_0007, 3'd2, 1'b1);

    // Random phases: receiver slow then sender slow, then both at full rate.
    plan_phase(38, 72, $urandom, ACT_DRAIN);
    plan_phase(72, 38, 32'hFFFF_FFFF, ACT_DRAIN);
    plan_phase(0, 0, 32'h0000_0000, ACT_HOLD);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (!plan_empty || hashes_due != hashes_seen) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
